[sv/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// Shared codes and types for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_QUERY      = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

endpackage

[sv/dq_ring_mem.sv]
// ----------------------------------------------------------------------------
// dq_ring_mem
// Ring store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dq_ring_mem #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32,
    parameter int ADDR_W     = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ADDR_W-1:0]     i_waddr,
    input  logic [WORD_WIDTH-1:0] i_wdata,
    input  logic                  i_re,
    input  logic [ADDR_W-1:0]     i_raddr,
    output logic [WORD_WIDTH-1:0] o_rdata
);

    logic [WORD_WIDTH-1:0] r_mem [DEPTH];
    logic [WORD_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/dq_ctrl.sv]
// ----------------------------------------------------------------------------
// dq_ctrl
// Position, count and end-word tracking; drives the ring store and refills
// an end word from the store after a pop.
// ----------------------------------------------------------------------------
module dq_ctrl #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32,
    parameter int ADDR_W     = $clog2(DEPTH),
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [dq_pkg::OP_W-1:0]         i_op,
    input  logic [WORD_WIDTH-1:0]           i_data,
    input  logic                            i_out_free,
    output logic                            o_ready,
    output logic                            o_res_valid,
    output logic [WORD_WIDTH-1:0]           o_popped,
    output logic [WORD_WIDTH-1:0]           o_head,
    output logic [WORD_WIDTH-1:0]           o_tail,
    output logic [CNT_W-1:0]                o_fill,
    output dq_pkg::t_status                 o_status,
    output logic                            o_we,
    output logic [ADDR_W-1:0]               o_waddr,
    output logic [WORD_WIDTH-1:0]           o_wdata,
    output logic                            o_re,
    output logic [ADDR_W-1:0]               o_raddr,
    input  logic [WORD_WIDTH-1:0]           i_rd_data
);

    import dq_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(DEPTH);

    t_state                r_state, n_state;
    logic [ADDR_W-1:0]     r_front, n_front;
    logic [ADDR_W-1:0]     r_back, n_back;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [WORD_WIDTH-1:0] r_head, n_head;
    logic [WORD_WIDTH-1:0] r_tail, n_tail;
    logic [WORD_WIDTH-1:0] r_pend_popped, n_pend_popped;
    logic                  r_pend_front, n_pend_front;

    logic                  w_acc;
    logic                  w_need_read;
    logic                  w_full;
    logic                  w_empty;
    logic [ADDR_W-1:0]     w_front_up, w_front_dn, w_back_up, w_back_dn, w_back_dn2;
    logic [WORD_WIDTH-1:0] w_popped;
    t_status               w_status;

    assign o_ready    = (r_state == S_IDLE) && i_out_free;
    assign w_acc      = i_valid && o_ready;
    assign w_full     = (r_count == FULL_CNT);
    assign w_empty    = (r_count == '0);
    assign w_front_up = (r_front == LAST_POS) ? '0 : r_front + 1'b1;
    assign w_front_dn = (r_front == '0) ? LAST_POS : r_front - 1'b1;
    assign w_back_up  = (r_back == LAST_POS) ? '0 : r_back + 1'b1;
    assign w_back_dn  = (r_back == '0) ? LAST_POS : r_back - 1'b1;
    assign w_back_dn2 = (w_back_dn == '0) ? LAST_POS : w_back_dn - 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && w_need_read) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_front       = r_front;
        n_back        = r_back;
        n_count       = r_count;
        n_head        = r_head;
        n_tail        = r_tail;
        n_pend_popped = r_pend_popped;
        n_pend_front  = r_pend_front;
        w_need_read   = 1'b0;
        w_popped      = '0;
        w_status      = ST_DONE;
        o_we          = 1'b0;
        o_waddr       = r_back;
        o_wdata       = i_data;
        o_re          = 1'b0;
        o_raddr       = w_front_up;

        if (r_state == S_READ) begin
            if (r_pend_front) begin
                n_head = i_rd_data;
            end else begin
                n_tail = i_rd_data;
            end
        end else if (w_acc) begin
            unique case (i_op)
                OP_PUSH_FRONT: begin
                    if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        o_we    = 1'b1;
                        o_waddr = w_front_dn;
                        n_front = w_front_dn;
                        n_count = r_count + 1'b1;
                        n_head  = i_data;
                        if (w_empty) begin
                            n_tail = i_data;
                        end
                    end
                end
                OP_PUSH_BACK: begin
                    if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        o_we    = 1'b1;
                        o_waddr = r_back;
                        n_back  = w_back_up;
                        n_count = r_count + 1'b1;
                        n_tail  = i_data;
                        if (w_empty) begin
                            n_head = i_data;
                        end
                    end
                end
                OP_POP_FRONT: begin
                    if (w_empty) begin
                        w_status = ST_EMPTY;
                    end else begin
                        w_popped      = r_head;
                        n_pend_popped = r_head;
                        n_pend_front  = 1'b1;
                        n_front       = w_front_up;
                        n_count       = r_count - 1'b1;
                        if (r_count == CNT_W'(2)) begin
                            n_head = r_tail;
                        end else if (r_count > CNT_W'(2)) begin
                            w_need_read = 1'b1;
                            o_re        = 1'b1;
                            o_raddr     = w_front_up;
                        end
                    end
                end
                OP_POP_BACK: begin
                    if (w_empty) begin
                        w_status = ST_EMPTY;
                    end else begin
                        w_popped      = r_tail;
                        n_pend_popped = r_tail;
                        n_pend_front  = 1'b0;
                        n_back        = w_back_dn;
                        n_count       = r_count - 1'b1;
                        if (r_count == CNT_W'(2)) begin
                            n_tail = r_head;
                        end else if (r_count > CNT_W'(2)) begin
                            w_need_read = 1'b1;
                            o_re        = 1'b1;
                            o_raddr     = w_back_dn2;
                        end
                    end
                end
                OP_CLEAR: begin
                    n_front = '0;
                    n_back  = '0;
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end

        o_res_valid = (r_state == S_READ) || (w_acc && !w_need_read);
        o_popped    = (r_state == S_READ) ? r_pend_popped : w_popped;
        o_status    = (r_state == S_READ) ? ST_DONE : w_status;
        o_fill      = n_count;
        o_head      = (n_count == '0) ? '0 : n_head;
        o_tail      = (n_count == '0) ? '0 : n_tail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head        <= n_head;
        r_tail        <= n_tail;
        r_pend_popped <= n_pend_popped;
        r_pend_front  <= n_pend_front;
    end

endmodule

[sv/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of words in a ring store, one result transaction per request.
// ----------------------------------------------------------------------------
// Each request transaction (op in tuser, word in tdata) gives exactly one
// result transaction. Push, clear, query, refused operations and pops that
// leave fewer than two words need no store read; a pop that leaves two or
// more words waits in the read state while the new end word is fetched
// through the ring store's registered read port, taking no new request. The
// front and back words are kept in registers, so pushes never read the store.
// The store needs no clearing pass after reset. The result register lets the
// next request be taken in the cycle its predecessor's result is handed over.
module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // data_in
    input  logic [((WORD_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // op
    input  logic [dq_pkg::OP_W-1:0]         i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // popped, head_word, tail_word, fill, status
    output logic [((3*WORD_WIDTH+$clog2(DEPTH+1)+dq_pkg::STATUS_W+7)/8)*8-1:0]
                                            o_m_axis_tdata
);

    import dq_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OUT_W  = 3*WORD_WIDTH + CNT_W + STATUS_W;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    logic                  w_out_free;
    logic                  w_res_valid;
    logic [WORD_WIDTH-1:0] w_popped, w_head, w_tail;
    logic [CNT_W-1:0]      w_fill;
    t_status               w_status;
    logic                  w_we, w_re;
    logic [ADDR_W-1:0]     w_waddr, w_raddr;
    logic [WORD_WIDTH-1:0] w_wdata, w_rdata;

    logic                  r_out_valid;
    logic [WORD_WIDTH-1:0] r_out_popped, r_out_head, r_out_tail;
    logic [CNT_W-1:0]      r_out_fill;
    t_status               r_out_status;

    assign w_out_free = !r_out_valid || i_m_axis_tready;

    dq_ctrl #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .i_op        (i_s_axis_tuser),
        .i_data      (i_s_axis_tdata[WORD_WIDTH-1:0]),
        .i_out_free  (w_out_free),
        .o_ready     (o_s_axis_tready),
        .o_res_valid (w_res_valid),
        .o_popped    (w_popped),
        .o_head      (w_head),
        .o_tail      (w_tail),
        .o_fill      (w_fill),
        .o_status    (w_status),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_re        (w_re),
        .o_raddr     (w_raddr),
        .i_rd_data   (w_rdata)
    );

    dq_ring_mem #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out_popped <= w_popped;
            r_out_head   <= w_head;
            r_out_tail   <= w_tail;
            r_out_fill   <= w_fill;
            r_out_status <= w_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TW'({r_out_status, r_out_fill, r_out_tail,
                                      r_out_head, r_out_popped});

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !w_res_valid)
        else $error("result overwritten while waiting");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_fill <= CNT_W'(DEPTH)))
        else $error("fill beyond depth");

    a_empty_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_EMPTY) |-> (r_out_fill == '0))
        else $error("pop refused while words held");

    a_full_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_FULL) |-> (r_out_fill == CNT_W'(DEPTH)))
        else $error("push refused while not full");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the double-ended queue.
// ----------------------------------------------------------------------------
// Requests go in as op plus word, and a mirror of the ring predicts each
// result transaction. The mirror tracks positions, count and stored words.
// A directed part covers the empty deque, filling to full, refused pushes and
// pops, and clear. A random part then walks the fill level up and down. It
// uses bursty requests, a stalling receiver and drain pauses along the way.
// ----------------------------------------------------------------------------
module tb;

    import dq_pkg::*;

    localparam int DEPTH   = 16;
    localparam int WORD_W  = 32;
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int IN_W    = ((WORD_W + 7) / 8) * 8;
    localparam int OUT_W   = ((3 * WORD_W + FILL_W + STATUS_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 624;

    // op codes outside the defined set, answered like a query
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        logic [WORD_W-1:0] popped;
        logic [WORD_W-1:0] head_word;
        logic [WORD_W-1:0] tail_word;
        logic [FILL_W-1:0] fill;
        t_status           status;
    } t_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [IN_W-1:0]   i_s_axis_tdata;   // data_in
    logic [OP_W-1:0]   i_s_axis_tuser;   // op
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [OUT_W-1:0]  o_m_axis_tdata;   // popped, head_word, tail_word, fill, status

    // mirror of the deque
    logic [WORD_W-1:0] mirror_store [DEPTH];
    int                mirror_front;
    int                mirror_back;
    int                mirror_fill;

    t_result           expected_results [$];
    int                error_count;
    int                burst_left;
    int                requests_sent;
    int                results_seen;
    int                pushes_refused;
    int                pops_refused;
    int                clears_sent;
    int                peak_hits;
    int                rx_mode;
    int                rx_mode_left;

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    function automatic int ring_next(input int pos);
        return (pos == DEPTH - 1) ? 0 : pos + 1;
    endfunction

    function automatic int ring_prev(input int pos);
        return (pos == 0) ? DEPTH - 1 : pos - 1;
    endfunction

    function automatic t_result predict_deque_result(input logic [OP_W-1:0] op,
                                                     input logic [WORD_W-1:0] word);
        t_result res;
        res.popped = '0;
        res.status = ST_DONE;
        case (op)
            OP_PUSH_FRONT: begin
                if (mirror_fill >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    mirror_front = ring_prev(mirror_front);
                    mirror_store[mirror_front] = word;
                    mirror_fill++;
                end
            end
            OP_PUSH_BACK: begin
                if (mirror_fill >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    mirror_store[mirror_back] = word;
                    mirror_back = ring_next(mirror_back);
                    mirror_fill++;
                end
            end
            OP_POP_FRONT: begin
                if (mirror_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.popped = mirror_store[mirror_front];
                    mirror_front = ring_next(mirror_front);
                    mirror_fill--;
                end
            end
            OP_POP_BACK: begin
                if (mirror_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    mirror_back = ring_prev(mirror_back);
                    res.popped = mirror_store[mirror_back];
                    mirror_fill--;
                end
            end
            OP_CLEAR: begin
                mirror_front = 0;
                mirror_back  = 0;
                mirror_fill  = 0;
            end
            default: begin
            end
        endcase
        if (mirror_fill == 0) begin
            res.head_word = '0;
            res.tail_word = '0;
        end else begin
            res.head_word = mirror_store[mirror_front];
            res.tail_word = mirror_store[ring_prev(mirror_back)];
        end
        res.fill = FILL_W'(mirror_fill);
        return res;
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word);
        int gap;
        t_result res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= IN_W'(word);
        do @(posedge i_clk); while (!o_s_axis_tready);
        res = predict_deque_result(op, word);
        expected_results = {expected_results, res};
        requests_sent++;
        if (res.status == ST_FULL) pushes_refused++;
        if (res.status == ST_EMPTY) pops_refused++;
        if (op == OP_CLEAR) clears_sent++;
        if (mirror_fill == DEPTH) peak_hits++;
    endtask

    // hold off new requests until every outstanding result is back
    task automatic wait_drain();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        return WORD_W'($urandom);
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return OP_CLEAR;
        if (r < 5) return OP_QUERY;
        if (r < 7) return ($urandom_range(0, 1) != 0) ? OP_SPARE_LO : OP_SPARE_HI;
        if ($urandom_range(0, 99) < push_pct) begin
            return ($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end
        return ($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    task automatic test_empty_deque();
        send_request(OP_POP_FRONT, 32'h1234_5678);
        send_request(OP_POP_BACK, '1);
        send_request(OP_QUERY, '0);
        send_request(OP_SPARE_HI, 32'hA5A5_5A5A);
        send_request(OP_CLEAR, '0);
        wait_drain();
    endtask

    task automatic test_fill_and_refuse();
        send_request(OP_PUSH_BACK, '0);
        send_request(OP_PUSH_FRONT, '1);
        for (int k = 2; k < DEPTH; k++) begin
            send_request((k % 2 != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, WORD_W'($urandom));
        end
        send_request(OP_PUSH_FRONT, 32'hDEAD_BEEF);
        send_request(OP_PUSH_BACK, 32'hCAFE_F00D);
        send_request(OP_POP_BACK, '0);
        send_request(OP_POP_FRONT, '0);
        send_request(OP_CLEAR, '0);
        wait_drain();
    endtask

    task automatic test_random_traffic();
        int phase_len;
        int push_pct;
        int sent;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0:       push_pct = 75;
                1:       push_pct = 25;
                default: push_pct = 50;
            endcase
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                send_request(pick_op(push_pct), pick_word());
                sent++;
            end
            if ($urandom_range(0, 3) == 0) wait_drain();
        end
        wait_drain();
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
                               input logic [WORD_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected: %0h", o_m_axis_tdata);
                error_count++;
            end else begin
                exp_r = expected_results[0];
                expected_results.delete(0);
                check_field("popped", exp_r.popped, o_m_axis_tdata[WORD_W-1:0]);
                check_field("head_word", exp_r.head_word, o_m_axis_tdata[2*WORD_W-1:WORD_W]);
                check_field("tail_word", exp_r.tail_word,
                            o_m_axis_tdata[3*WORD_W-1:2*WORD_W]);
                check_field("fill", WORD_W'(exp_r.fill),
                            WORD_W'(o_m_axis_tdata[3*WORD_W+FILL_W-1:3*WORD_W]));
                check_field("status", WORD_W'(exp_r.status),
                            WORD_W'(o_m_axis_tdata[3*WORD_W+FILL_W+STATUS_W-1:3*WORD_W+FILL_W]));
            end
        end
    end

    // receiver: always ready, coin-toss, or mostly stalled, in changing phases
    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(20, 60);
        end
        rx_mode_left = rx_mode_left - 1;
        case (rx_mode)
            0:       i_m_axis_tready <= 1'b1;
            1:       i_m_axis_tready <= ($urandom_range(0, 1) != 0);
            default: i_m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = OP_QUERY;
        i_m_axis_tready = 1'b0;
        rx_mode         = 0;
        rx_mode_left    = 0;
        error_count     = 0;
        burst_left      = 0;
        requests_sent   = 0;
        results_seen    = 0;
        pushes_refused  = 0;
        pops_refused    = 0;
        clears_sent     = 0;
        peak_hits       = 0;
        mirror_front    = 0;
        mirror_back     = 0;
        mirror_fill     = 0;
        for (int k = 0; k < DEPTH; k++) mirror_store[k] = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_deque();
        test_fill_and_refuse();
        test_random_traffic();

        repeat (10) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d result transactions never arrived", expected_results.size());
            error_count++;
        end
        $display("ran %0d requests, %0d results: %0d refused pushes, %0d refused pops,",
                 requests_sent, results_seen, pushes_refused, pops_refused);
        $display("%0d clears, %0d requests leaving the deque full", clears_sent, peak_hits);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
